[rtl/core/dq_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the double-ended queue.
package dq_pkg;

   localparam int DEPTH     = 64;
   localparam int WORD_BITS = 32;
   localparam int CNT_BITS  = $clog2(DEPTH + 1);

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [CNT_BITS-1:0]  count_type;

   localparam count_type FULL_COUNT = count_type'(DEPTH);

   typedef enum logic [2:0] {
      ACT_NOP        = 3'd0,
      ACT_PUSH_BACK  = 3'd1,
      ACT_PUSH_FRONT = 3'd2,
      ACT_POP_BACK   = 3'd3,
      ACT_POP_FRONT  = 3'd4,
      ACT_CLEAR      = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_PUSH_BACK,
      CELL_PUSH_FRONT,
      CELL_POP_BACK,
      CELL_POP_FRONT,
      CELL_CLEAR
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      word_type    word;
   } cell_ctl_type;

   typedef enum logic {
      ST_IDLE,
      ST_REPLY
   } state_type;

endpackage

[rtl/core/dq_cell.sv]
`timescale 1ns / 1ps
// One storage cell of the queue row, holding one word and its valid flag.
module dq_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  dq_pkg::cell_ctl_type ctl,
   input  dq_pkg::word_type     prev_data,
   input  logic                 prev_valid,
   input  dq_pkg::word_type     next_data,
   input  logic                 next_valid,
   output dq_pkg::word_type     data_out,
   output logic                 valid_out,
   output dq_pkg::word_type     back_tap
);

   dq_pkg::word_type data_ff;
   dq_pkg::word_type data_in;
   logic             valid_ff;
   logic             valid_in;

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      case (ctl.op)
         dq_pkg::CELL_HOLD: begin
         end
         dq_pkg::CELL_PUSH_BACK: begin
            // Only the first empty cell behind the occupied run takes the word.
            if (!valid_ff && prev_valid) begin
               valid_in = 1'b1;
               data_in  = ctl.word;
            end
         end
         dq_pkg::CELL_PUSH_FRONT: begin
            valid_in = prev_valid;
            data_in  = prev_data;
         end
         dq_pkg::CELL_POP_BACK: begin
            if (valid_ff && !next_valid) begin
               valid_in = 1'b0;
            end
         end
         dq_pkg::CELL_POP_FRONT: begin
            valid_in = next_valid;
            data_in  = next_data;
         end
         dq_pkg::CELL_CLEAR: begin
            valid_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out  = data_ff;
   assign valid_out = valid_ff;
   assign back_tap  = (valid_ff && !next_valid) ? data_ff : '0;

endmodule

[rtl/core/double_ended_queue_top.sv]
`timescale 1ns / 1ps
// Top level of the double-ended queue: command handling over a row of cells.
//
// The queue keeps its words packed at the front of a row of cells, the first word
// in cell zero, and every command moves the whole row by one cell at most. The
// request beat is accepted and the row updated while idle, and the result beat is
// offered from the next cycle on. A new request beat is accepted once the result
// beat has been taken, so the block does not take a new item before the result of
// the last one has been taken. The popped word and the status are registered;
// front word and back word are read from the row, and they and the count stay
// steady while the result waits.
module double_ended_queue_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [2:0]        req_action,
   input  dq_pkg::word_type  req_value,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dq_pkg::word_type  rsp_popped,
   output dq_pkg::word_type  rsp_front_word,
   output dq_pkg::word_type  rsp_back_word,
   output dq_pkg::count_type rsp_count,
   output logic [1:0]        rsp_status
);

   dq_pkg::state_type    state_ff;
   dq_pkg::state_type    state_in;
   dq_pkg::count_type    count_ff;
   dq_pkg::count_type    count_in;
   dq_pkg::word_type     popped_ff;
   dq_pkg::word_type     popped_in;
   dq_pkg::status_type   status_ff;
   dq_pkg::status_type   status_in;
   dq_pkg::cell_ctl_type cell_ctl;

   dq_pkg::word_type        cell_data [dq_pkg::DEPTH];
   dq_pkg::word_type        cell_tap  [dq_pkg::DEPTH];
   logic [dq_pkg::DEPTH-1:0] cell_valid;
   dq_pkg::word_type        back_word;
   dq_pkg::word_type        front_word;

   genvar gi;
   generate
      for (gi = 0; gi < dq_pkg::DEPTH; gi++) begin : g_cell
         dq_pkg::word_type prev_data;
         logic             prev_valid;
         dq_pkg::word_type next_data;
         logic             next_valid;

         if (gi == 0) begin : g_first
            assign prev_data  = req_value;
            assign prev_valid = 1'b1;
         end else begin : g_mid_prev
            assign prev_data  = cell_data[gi-1];
            assign prev_valid = cell_valid[gi-1];
         end

         if (gi == dq_pkg::DEPTH - 1) begin : g_last
            assign next_data  = '0;
            assign next_valid = 1'b0;
         end else begin : g_mid_next
            assign next_data  = cell_data[gi+1];
            assign next_valid = cell_valid[gi+1];
         end

         dq_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (cell_ctl),
            .prev_data  (prev_data),
            .prev_valid (prev_valid),
            .next_data  (next_data),
            .next_valid (next_valid),
            .data_out   (cell_data[gi]),
            .valid_out  (cell_valid[gi]),
            .back_tap   (cell_tap[gi])
         );
      end
   endgenerate

   // Only the last occupied cell drives a nonzero tap, so an OR gives the back word.
   always_comb begin
      back_word = '0;
      for (int i = 0; i < dq_pkg::DEPTH; i++) begin
         back_word = back_word | cell_tap[i];
      end
   end

   assign front_word = cell_valid[0] ? cell_data[0] : '0;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      popped_in     = popped_ff;
      status_in     = status_ff;
      cell_ctl.op   = dq_pkg::CELL_HOLD;
      cell_ctl.word = req_value;
      case (state_ff)
         dq_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in  = dq_pkg::ST_REPLY;
               popped_in = '0;
               status_in = dq_pkg::STAT_OK;
               case (dq_pkg::action_type'(req_action))
                  dq_pkg::ACT_PUSH_BACK: begin
                     if (count_ff == dq_pkg::FULL_COUNT) begin
                        status_in = dq_pkg::STAT_FULL;
                     end else begin
                        cell_ctl.op = dq_pkg::CELL_PUSH_BACK;
                        count_in    = count_ff + dq_pkg::count_type'(1);
                     end
                  end
                  dq_pkg::ACT_PUSH_FRONT: begin
                     if (count_ff == dq_pkg::FULL_COUNT) begin
                        status_in = dq_pkg::STAT_FULL;
                     end else begin
                        cell_ctl.op = dq_pkg::CELL_PUSH_FRONT;
                        count_in    = count_ff + dq_pkg::count_type'(1);
                     end
                  end
                  dq_pkg::ACT_POP_BACK: begin
                     if (count_ff == '0) begin
                        status_in = dq_pkg::STAT_EMPTY;
                     end else begin
                        cell_ctl.op = dq_pkg::CELL_POP_BACK;
                        popped_in   = back_word;
                        count_in    = count_ff - dq_pkg::count_type'(1);
                     end
                  end
                  dq_pkg::ACT_POP_FRONT: begin
                     if (count_ff == '0) begin
                        status_in = dq_pkg::STAT_EMPTY;
                     end else begin
                        cell_ctl.op = dq_pkg::CELL_POP_FRONT;
                        popped_in   = cell_data[0];
                        count_in    = count_ff - dq_pkg::count_type'(1);
                     end
                  end
                  dq_pkg::ACT_CLEAR: begin
                     cell_ctl.op = dq_pkg::CELL_CLEAR;
                     count_in    = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         dq_pkg::ST_REPLY: begin
            if (rsp_ready) begin
               state_in = dq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= dq_pkg::ST_IDLE;
         count_ff  <= '0;
         status_ff <= dq_pkg::STAT_OK;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      popped_ff <= popped_in;
   end

   assign req_ready      = (state_ff == dq_pkg::ST_IDLE);
   assign rsp_valid      = (state_ff == dq_pkg::ST_REPLY);
   assign rsp_popped     = popped_ff;
   assign rsp_front_word = front_word;
   assign rsp_back_word  = back_word;
   assign rsp_count      = count_ff;
   assign rsp_status     = status_ff;

`ifndef SYNTHESIS
   // The number of occupied cells always equals the count.
   a_valid_matches_count: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == int'(count_ff))
      else $error("cell valid flags disagree with count");

   a_packed_front: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> cell_valid[0])
      else $error("occupied run does not start at the first cell");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == dq_pkg::STAT_FULL) |-> (count_ff == dq_pkg::FULL_COUNT))
      else $error("full status reported on a queue that is not full");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == dq_pkg::STAT_EMPTY) |-> (count_ff == '0 && rsp_popped == '0))
      else $error("empty status reported on a queue that is not empty");

   a_row_steady: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(cell_valid) && $stable(count_ff)))
      else $error("cell row changed while a result beat was pending");
`endif

endmodule
